>>> rtl/core/four_connected_line_walker_core_defines.svh
// Assertion helpers for the line walker core.
// Both sample on clk and are switched off while rst_n is low.
`ifndef FOUR_CONNECTED_LINE_WALKER_CORE_DEFINES_SVH
`define FOUR_CONNECTED_LINE_WALKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define FCLW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCLW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/fclw_pkg.sv
package fclw_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int VIEW_W          = 15;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [VIEW_W-1:0] VP_WIDTH_RST  = 15'd640;
    localparam logic [VIEW_W-1:0] VP_HEIGHT_RST = 15'd480;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_VP_WIDTH  = 1'b0,
        REG_VP_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // per-request outcome from the walker datapath
    typedef struct packed {
        logic emit;
        logic last;
    } step_ctrl_t;

endpackage

>>> rtl/core/fclw_apb_regs.sv
module fclw_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fclw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fclw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fclw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [fclw_pkg::VIEW_W-1:0]        vp_width,
    output logic [fclw_pkg::VIEW_W-1:0]        vp_height
);

    logic [fclw_pkg::VIEW_W-1:0] vp_width_reg;
    logic [fclw_pkg::VIEW_W-1:0] vp_height_reg;
    logic                        wr_en;
    fclw_pkg::reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = fclw_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_width_reg  <= fclw_pkg::VP_WIDTH_RST;
            vp_height_reg <= fclw_pkg::VP_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                fclw_pkg::REG_VP_WIDTH:
                begin
                    vp_width_reg <= pwdata[fclw_pkg::VIEW_W-1:0];
                end
                fclw_pkg::REG_VP_HEIGHT:
                begin
                    vp_height_reg <= pwdata[fclw_pkg::VIEW_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            fclw_pkg::REG_VP_WIDTH:
                prdata = fclw_pkg::APB_DATA_W'(vp_width_reg);
            fclw_pkg::REG_VP_HEIGHT:
                prdata = fclw_pkg::APB_DATA_W'(vp_height_reg);
            default:
                prdata = '0;
        endcase
    end

    assign vp_width  = vp_width_reg;
    assign vp_height = vp_height_reg;

endmodule

>>> rtl/core/fclw_step.sv
module fclw_step #(
    parameter int COORD_WIDTH = fclw_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           operation,
    input  logic [COORD_WIDTH-1:0]         start_x,
    input  logic [COORD_WIDTH-1:0]         start_y,
    input  logic [COORD_WIDTH-1:0]         end_x,
    input  logic [COORD_WIDTH-1:0]         end_y,
    output fclw_pkg::step_ctrl_t           ctrl,
    output logic [COORD_WIDTH-1:0]         pixel_x,
    output logic [COORD_WIDTH-1:0]         pixel_y
);

    localparam int DW = COORD_WIDTH + 1;   // |delta|
    localparam int RW = COORD_WIDTH + 2;   // moves left
    localparam int EW = COORD_WIDTH + 3;   // error term, signed

    logic [DW-1:0]        delta_x_reg, delta_x_next;
    logic [DW-1:0]        delta_y_reg, delta_y_next;
    logic                 x_major_reg, x_major_next;
    logic                 dir_x_neg_reg, dir_x_neg_next;
    logic                 dir_y_neg_reg, dir_y_neg_next;
    logic [COORD_WIDTH-1:0] cur_x_reg, cur_x_next;
    logic [COORD_WIDTH-1:0] cur_y_reg, cur_y_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic [RW-1:0]        remain_reg, remain_next;
    logic                 active_reg, active_next;

    logic signed [DW-1:0] sx_e, sy_e, ex_e, ey_e;
    logic                 ld_dir_x_neg, ld_dir_y_neg;
    logic [DW-1:0]        ld_dx, ld_dy;
    logic [DW-1:0]        major, minor;
    logic signed [EW-1:0] twice_major, twice_minor;
    logic                 err_pos, move_x;
    fclw_pkg::op_t        op;

    assign op = fclw_pkg::op_t'(operation);

    // start: endpoint differences
    assign sx_e = $signed({start_x[COORD_WIDTH-1], start_x});
    assign sy_e = $signed({start_y[COORD_WIDTH-1], start_y});
    assign ex_e = $signed({end_x[COORD_WIDTH-1], end_x});
    assign ey_e = $signed({end_y[COORD_WIDTH-1], end_y});

    assign ld_dir_x_neg = ex_e < sx_e;
    assign ld_dir_y_neg = ey_e < sy_e;
    assign ld_dx = ld_dir_x_neg ? DW'(sx_e - ex_e) : DW'(ex_e - sx_e);
    assign ld_dy = ld_dir_y_neg ? DW'(sy_e - ey_e) : DW'(ey_e - sy_e);

    // step: error-term decision
    assign major       = x_major_reg ? delta_x_reg : delta_y_reg;
    assign minor       = x_major_reg ? delta_y_reg : delta_x_reg;
    assign twice_major = $signed({1'b0, major, 1'b0});
    assign twice_minor = $signed({1'b0, minor, 1'b0});
    assign err_pos     = !err_reg[EW-1] && (err_reg != '0);
    assign move_x      = err_pos ? !x_major_reg : x_major_reg;

    always_comb
    begin
        delta_x_next   = delta_x_reg;
        delta_y_next   = delta_y_reg;
        x_major_next   = x_major_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        remain_next    = remain_reg;
        active_next    = active_reg;
        ctrl.emit      = 1'b0;
        ctrl.last      = 1'b0;

        if (accept)
        begin
            priority if (op == fclw_pkg::OP_START)
            begin
                delta_x_next   = ld_dx;
                delta_y_next   = ld_dy;
                x_major_next   = ld_dy <= ld_dx;
                dir_x_neg_next = ld_dir_x_neg;
                dir_y_neg_next = ld_dir_y_neg;
                cur_x_next     = start_x;
                cur_y_next     = start_y;
                err_next       = '0;
                remain_next    = RW'(ld_dx) + RW'(ld_dy);
                active_next    = 1'b1;
                ctrl.emit      = 1'b1;
                ctrl.last      = (start_x == end_x) && (start_y == end_y);
            end
            else if (!active_reg)
            begin
                // no line loaded: swallow the step
            end
            else if (remain_reg == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_pos ? (err_reg - twice_major) : (err_reg + twice_minor);
                if (move_x)
                begin
                    cur_x_next = dir_x_neg_reg ? (cur_x_reg - COORD_WIDTH'(1))
                                               : (cur_x_reg + COORD_WIDTH'(1));
                end
                else
                begin
                    cur_y_next = dir_y_neg_reg ? (cur_y_reg - COORD_WIDTH'(1))
                                               : (cur_y_reg + COORD_WIDTH'(1));
                end
                remain_next = remain_reg - RW'(1);
                ctrl.emit   = 1'b1;
                ctrl.last   = remain_reg == RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            x_major_reg   <= 1'b0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            remain_reg    <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            x_major_reg   <= x_major_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            err_reg       <= err_next;
            remain_reg    <= remain_next;
            active_reg    <= active_next;
        end
    end

    assign pixel_x = cur_x_next;
    assign pixel_y = cur_y_next;

endmodule

>>> rtl/core/four_connected_line_walker_core.sv
// Four-connected line walker. A start request (operation 0) loads two signed
// endpoints and yields the first pixel; each step request (operation 1) yields
// the next pixel, moving along x or y but never both, until delta_x+delta_y+1
// pixels have gone out, the final one flagged last. A step with no line loaded,
// or one past the end, yields nothing (the latter also retires the line).
// in_view is 1 when 0 <= x < vp_width and 0 <= y < vp_height, set over the
// APB port (vp_width at 0x0, vp_height at 0x4, reset 640 x 480); write the
// viewport only with no result outstanding. Rate: one request per clock
// unless stalled; each result appears in the cycle after acceptance. The
// walker state sits in one register bank updated from a single add, sign test
// and compare each cycle, and one output register decouples the stall: a new
// request is taken whenever that register is empty or being drained.
`include "four_connected_line_walker_core_defines.svh"

module four_connected_line_walker_core #(
    parameter int COORD_WIDTH = fclw_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fclw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fclw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fclw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic signed [COORD_WIDTH-1:0]      start_x,
    input  logic signed [COORD_WIDTH-1:0]      start_y,
    input  logic signed [COORD_WIDTH-1:0]      end_x,
    input  logic signed [COORD_WIDTH-1:0]      end_y,
    // pixel channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [COORD_WIDTH-1:0]      pixel_x,
    output logic signed [COORD_WIDTH-1:0]      pixel_y,
    output logic                               in_view,
    output logic                               last
);

    // wide enough for both a non-negative coordinate and a viewport size
    localparam int CMP_W = ((COORD_WIDTH > fclw_pkg::VIEW_W) ?
                            COORD_WIDTH : fclw_pkg::VIEW_W) + 1;

    logic [fclw_pkg::VIEW_W-1:0] vp_width;
    logic [fclw_pkg::VIEW_W-1:0] vp_height;

    logic                        in_accept;
    fclw_pkg::step_ctrl_t        step_ctrl;
    logic [COORD_WIDTH-1:0]      step_x;
    logic [COORD_WIDTH-1:0]      step_y;

    logic                        out_valid_reg, out_valid_next;
    logic [COORD_WIDTH-1:0]      pixel_x_reg;
    logic [COORD_WIDTH-1:0]      pixel_y_reg;
    logic                        last_reg;
    logic                        x_in, y_in;

    fclw_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .vp_width  (vp_width),
        .vp_height (vp_height)
    );

    // Output register full and held -> hold off the request side.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    fclw_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .operation (operation),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .ctrl      (step_ctrl),
        .pixel_x   (step_x),
        .pixel_y   (step_y)
    );

    // Register refills whenever not stalled; empties if nothing new arrives.
    assign out_valid_next = in_stall ? out_valid_reg : (in_accept && step_ctrl.emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, loaded only with a fresh pixel
    always_ff @(posedge clk)
    begin
        if (in_accept && step_ctrl.emit)
        begin
            pixel_x_reg <= step_x;
            pixel_y_reg <= step_y;
            last_reg    <= step_ctrl.last;
        end
    end

    // Viewport test on the held pixel; the user must keep the viewport static while
    // a result is pending (the block does not enforce it), so it is not registered.
    assign x_in = !pixel_x_reg[COORD_WIDTH-1] &&
                  (CMP_W'(pixel_x_reg) < CMP_W'(vp_width));
    assign y_in = !pixel_y_reg[COORD_WIDTH-1] &&
                  (CMP_W'(pixel_y_reg) < CMP_W'(vp_height));

    assign out_valid = out_valid_reg;
    assign pixel_x   = $signed(pixel_x_reg);
    assign pixel_y   = $signed(pixel_y_reg);
    assign in_view   = x_in && y_in;
    assign last      = last_reg;

    // checks
    `FCLW_ASSERT_IMP(a_stall_needs_full, in_stall, out_valid_reg, "stall with empty output register")
    `FCLW_ASSERT_NXT(a_start_emits, in_accept && (operation == fclw_pkg::OP_START), out_valid_reg, "start request gave no pixel")
    `FCLW_ASSERT_NXT(a_start_pixel, in_accept && (operation == fclw_pkg::OP_START), (pixel_x_reg == $past(start_x)) && (pixel_y_reg == $past(start_y)), "first pixel is not the start point")
    `FCLW_ASSERT_NXT(a_start_last, in_accept && (operation == fclw_pkg::OP_START), last_reg == (($past(start_x) == $past(end_x)) && ($past(start_y) == $past(end_y))), "last flag wrong on first pixel")

endmodule
